### rtl/firq31_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firq31_pkg
// Shared types and constants for the Q1.31 direct-form FIR core: tap count,
// address widths, sequencer states and the control structs between modules.
// ----------------------------------------------------------------------------
package firq31_pkg;

  localparam int TAPS     = 1024;
  localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int ACC_W    = 64;
  localparam int SHIFT_W  = 6;
  localparam int INDEX_W  = 10;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd28;
  localparam logic [TAP_AW-1:0]  TAP_LAST    = TAP_AW'(TAPS - 1);
  localparam logic [CNT_W-1:0]   FILL_FULL   = CNT_W'(TAPS);

  typedef logic [TAP_AW-1:0] tap_addr_t;

  // request opcode
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // sequencer -> tap storage
  typedef struct packed {
    logic      hist_we;
    tap_addr_t hist_waddr;
    tap_addr_t hist_raddr;
    logic      coef_we;
    tap_addr_t coef_waddr;
    tap_addr_t coef_raddr;
  } mem_ctl_t;

  // sequencer -> multiply-accumulate unit
  typedef struct packed {
    logic clear;  // start of a new sum
    logic issue;  // a tap read was issued this cycle
    logic live;   // history entry of this tap has been written since reset
  } mac_ctl_t;

  // map the request's tap index onto a storage address
  function automatic tap_addr_t index_to_addr(logic [INDEX_W-1:0] idx);
    logic [TAP_AW+INDEX_W-1:0] wide;
    wide = {{TAP_AW{1'b0}}, idx};
    return wide[TAP_AW-1:0];
  endfunction

endpackage

### rtl/firq31_taps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firq31_taps
// Tap storage: the circular sample delay line and the coefficient table,
// each a single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module firq31_taps (
  input  logic                                  clk,
  input  firq31_pkg::mem_ctl_t                  mem_ctl,
  input  logic signed [firq31_pkg::SAMPLE_W-1:0] wr_sample,
  input  logic signed [firq31_pkg::COEF_W-1:0]   wr_coef,
  output logic signed [firq31_pkg::SAMPLE_W-1:0] hist_rd,
  output logic signed [firq31_pkg::COEF_W-1:0]   coef_rd
);
  import firq31_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_mem [TAPS];

  // delay line
  always_ff @(posedge clk) begin
    if (mem_ctl.hist_we) begin
      hist_mem[mem_ctl.hist_waddr] <= wr_sample;
    end
    hist_rd <= hist_mem[mem_ctl.hist_raddr];
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (mem_ctl.coef_we) begin
      coef_mem[mem_ctl.coef_waddr] <= wr_coef;
    end
    coef_rd <= coef_mem[mem_ctl.coef_raddr];
  end

endmodule

### rtl/firq31_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firq31_mac
// Shared multiply-accumulate unit: one 32x32 signed product per cycle into a
// product register, a 64-bit wrapping accumulator, and the output shifter.
// ----------------------------------------------------------------------------
module firq31_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  firq31_pkg::mac_ctl_t                   mac_ctl,
  input  logic signed [firq31_pkg::SAMPLE_W-1:0] hist_rd,
  input  logic signed [firq31_pkg::COEF_W-1:0]   coef_rd,
  input  logic [firq31_pkg::SHIFT_W-1:0]         shift,
  output logic                                   pipe_busy,
  output logic signed [firq31_pkg::SAMPLE_W-1:0] result
);
  import firq31_pkg::*;

  logic                    rd_vld_r;
  logic                    rd_live_r;
  logic                    prod_vld_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] product;
  logic signed [ACC_W-1:0] shifted;

  // pipeline valids track the registered memory read and the product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_live_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= mac_ctl.issue;
      rd_live_r  <= mac_ctl.live;
      prod_vld_r <= rd_vld_r;
    end
  end

  // full-width signed product
  assign product = hist_rd * coef_rd;

  // unwritten history slots read as zero
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= rd_live_r ? product : '0;
    end
  end

  // accumulate, wrapping mod 2^64
  always_ff @(posedge clk) begin
    if (mac_ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign pipe_busy = rd_vld_r | prod_vld_r;
  assign shifted   = acc_r >>> shift;
  assign result    = shifted[SAMPLE_W-1:0];

endmodule

### rtl/firq31_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firq31_ctrl
// Sequencer: takes requests, keeps the delay-line head and fill count, and
// walks every tap through the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module firq31_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [firq31_pkg::INDEX_W-1:0]      in_tap_index,
  input  logic                                pipe_busy,
  input  logic                                out_free,
  output firq31_pkg::mem_ctl_t                mem_ctl,
  output firq31_pkg::mac_ctl_t                mac_ctl,
  output logic                                done
);
  import firq31_pkg::*;

  seq_state_t       state_r, state_nxt;
  tap_addr_t        head_r;     // slot of newest sample
  tap_addr_t        rd_pos_r;   // delay-line read slot
  tap_addr_t        tap_r;      // coefficient index
  logic [CNT_W-1:0] fill_r;     // samples written since reset, saturating

  logic      accept;
  logic      sample_acc;
  logic      coef_acc;
  logic      tap_ok;
  tap_addr_t head_new;
  tap_addr_t rd_pos_inc;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign sample_acc = accept && (op_t'(in_op) == OP_SAMPLE);
  assign coef_acc   = accept && (op_t'(in_op) == OP_COEF);
  assign tap_ok     = (int'(in_tap_index) < TAPS);
  assign head_new   = (head_r == '0) ? TAP_LAST : tap_addr_t'(head_r - 1'b1);
  assign rd_pos_inc = (rd_pos_r == TAP_LAST) ? '0 : tap_addr_t'(rd_pos_r + 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sample_acc) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tap_r == TAP_LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall           = (state_r != ST_IDLE);
    done               = (state_r == ST_DRAIN) && !pipe_busy && out_free;
    mem_ctl.hist_we    = sample_acc;
    mem_ctl.hist_waddr = head_new;
    mem_ctl.hist_raddr = rd_pos_r;
    mem_ctl.coef_we    = coef_acc && tap_ok;
    mem_ctl.coef_waddr = index_to_addr(in_tap_index);
    mem_ctl.coef_raddr = tap_r;
    mac_ctl.clear      = sample_acc;
    mac_ctl.issue      = (state_r == ST_RUN);
    mac_ctl.live       = (CNT_W'(tap_r) < fill_r);
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      rd_pos_r <= '0;
      tap_r    <= '0;
      fill_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (sample_acc) begin
        head_r   <= head_new;
        rd_pos_r <= head_new;
        tap_r    <= '0;
        if (fill_r != FILL_FULL) fill_r <= fill_r + 1'b1;
      end else if (state_r == ST_RUN) begin
        rd_pos_r <= rd_pos_inc;
        if (tap_r != TAP_LAST) tap_r <= tap_r + 1'b1;
      end
    end
  end

endmodule

### rtl/fir_filter_q31_core.sv
`timescale 1ns / 1ps
// A sample request walks every tap (TAPS, 1024 taps) in turn through one shared
// 32x32 multiplier, which handles one tap a cycle; new requests are stalled
// until the result is in the output register. A coefficient write leaves it idle.
// Reset (rst_n low, synchronous): delay line reads as zero, output_shift is 28,
// no result pending; no clearing pass, a fill count masks unwritten slots.
// ----------------------------------------------------------------------------
// fir_filter_q31_core
// Direct-form FIR filter for Q1.31 samples and Q4.28 coefficients with a
// 64-bit accumulator and a programmable arithmetic output shift.
// ----------------------------------------------------------------------------
module fir_filter_q31_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_op,
  input  logic signed [firq31_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [firq31_pkg::INDEX_W-1:0]         in_tap_index,
  input  logic signed [firq31_pkg::COEF_W-1:0]   in_tap_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [firq31_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                   cfg_we,
  input  logic [firq31_pkg::SHIFT_W-1:0]         cfg_wdata
);
  import firq31_pkg::*;

  mem_ctl_t                   mem_ctl;
  mac_ctl_t                   mac_ctl;
  logic                       pipe_busy;
  logic                       out_free;
  logic                       done;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic signed [COEF_W-1:0]   coef_rd;
  logic signed [SAMPLE_W-1:0] result;
  logic [SHIFT_W-1:0]         shift_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // output shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  firq31_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_tap_index (in_tap_index),
    .pipe_busy    (pipe_busy),
    .out_free     (out_free),
    .mem_ctl      (mem_ctl),
    .mac_ctl      (mac_ctl),
    .done         (done)
  );

  firq31_taps u_taps (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .wr_sample (in_sample_in),
    .wr_coef   (in_tap_value),
    .hist_rd   (hist_rd),
    .coef_rd   (coef_rd)
  );

  firq31_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .mac_ctl   (mac_ctl),
    .hist_rd   (hist_rd),
    .coef_rd   (coef_rd),
    .shift     (shift_r),
    .pipe_busy (pipe_busy),
    .result    (result)
  );

  // output register; frees when the current result is taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

### rtl/firq31_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firq31_checker
// Port-level checks for the FIR core, bound onto the top level.
// ----------------------------------------------------------------------------
module firq31_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   in_op,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [firq31_pkg::SAMPLE_W-1:0] out_sample_out
);
  import firq31_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  // a sample request makes the core busy for the tap walk
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (op_t'(in_op) == OP_SAMPLE) |=> in_stall)
    else $error("core not busy after sample request");

  // a coefficient write leaves the core ready
  a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (op_t'(in_op) == OP_COEF) |=> !in_stall)
    else $error("core busy after coefficient write");

  // reset leaves the core ready with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

endmodule

bind fir_filter_q31_core firq31_checker u_firq31_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);

### tb/fir_filter_q31_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_q31_core_test
// Self-checking bench for the Q1.31 FIR core. It zeroes the coefficient bank,
// walks a table of edge cases, then runs a random mix of samples, coefficient
// updates and output shifts, checking every filtered output against a typed-in
// expectation or an in-bench model of the delay line and accumulator.
// ----------------------------------------------------------------------------
module fir_filter_q31_core_test;
  import firq31_pkg::*;

  localparam int LATENCY    = TAPS + 3;
  localparam int CFG_SLACK  = 8;               // idle wait before an output shift write
  localparam int IDLE_LIMIT = 8 * TAPS + 2000; // one tap walk plus worst stalls and gaps
  localparam int RAND_ITEMS = 580;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_SHIFT
  } row_kind_t;

  // one line of the directed table; shift rows carry the shift in val
  typedef struct packed {
    row_kind_t          kind;
    op_t                op;
    logic [31:0]        smp;
    logic [INDEX_W-1:0] idx;
    logic [31:0]        val;
    logic               has_exp;
    logic [31:0]        exp_out;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // all taps zero: output is zero
    '{ROW_REQ,   OP_SAMPLE, 32'h7FFF_FFFF, 10'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
    // unity gain on the newest tap passes the sample through at shift 28
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'd0,   32'h1000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'd0,   32'h0000_0000, 1'b1, 32'h8000_0000},
    '{ROW_REQ,   OP_SAMPLE, 32'h7FFF_FFFF, 10'd0,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    // oldest tap, paired with a slot that is still zero
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'h3FF, 32'hF000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h0000_0001, 10'h3FF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // no shift: low word of the raw sum
    '{ROW_SHIFT, OP_SAMPLE, 32'h0000_0000, 10'd0,   32'd0,         1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h1234_5678, 10'h155, 32'hAAAA_5555, 1'b0, 32'h0},
    // largest shift leaves only the sign
    '{ROW_SHIFT, OP_SAMPLE, 32'h0000_0000, 10'd0,   32'd63,        1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'h2AA, 32'h5555_AAAA, 1'b1, 32'hFFFF_FFFF},
    '{ROW_REQ,   OP_SAMPLE, 32'h0000_0005, 10'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
    // four products of 2^62 wrap the accumulator to zero
    '{ROW_SHIFT, OP_SAMPLE, 32'h0000_0000, 10'd0,   32'd0,         1'b0, 32'h0},
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'd0,   32'h8000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'd1,   32'h8000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'd2,   32'h8000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_COEF,   32'h0000_0000, 10'd3,   32'h8000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'd0,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'd0,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'd0,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h8000_0000, 10'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SHIFT, OP_SAMPLE, 32'h0000_0000, 10'd0,   32'd31,        1'b0, 32'h0},
    '{ROW_REQ,   OP_SAMPLE, 32'h4000_0000, 10'd0,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SHIFT, OP_SAMPLE, 32'h0000_0000, 10'd0,   32'd28,        1'b0, 32'h0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic [INDEX_W-1:0]        in_tap_index;
  logic signed [COEF_W-1:0]  in_tap_value;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                      cfg_we;
  logic [SHIFT_W-1:0]        cfg_wdata;

  // typed-in expectation travelling with the current request
  logic                      row_has_exp;
  logic [31:0]               row_exp_out;

  // filter model state
  logic signed [31:0]        delay_line [TAPS];
  logic signed [31:0]        coef_bank  [TAPS];
  int unsigned               newest_slot;
  logic [SHIFT_W-1:0]        out_shift;
  logic [31:0]               expected_out [$];

  int burst_left     = 0;
  int idle_cycles    = 0;
  int n_samples      = 0;
  int n_coef_writes  = 0;
  int n_shift_writes = 0;
  int n_outputs      = 0;
  int n_errors       = 0;

  fir_filter_q31_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_sample_in  (in_sample_in),
    .in_tap_index  (in_tap_index),
    .in_tap_value  (in_tap_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // push one sample into the delay line and form the shifted, narrowed sum
  function automatic logic [31:0] fir_predict(logic signed [31:0] s);
    logic signed [63:0] acc;
    logic signed [63:0] h;
    logic signed [63:0] c;
    logic signed [63:0] shifted;
    int unsigned        slot;
    newest_slot = (newest_slot == 0) ? TAPS - 1 : newest_slot - 1;
    delay_line[newest_slot] = s;
    slot = newest_slot;
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      h = delay_line[slot];
      c = coef_bank[k];
      acc = acc + h * c; // wraps mod 2^64
      slot = (slot + 1 >= TAPS) ? 0 : slot + 1;
    end
    shifted = acc >>> out_shift;
    return shifted[31:0];
  endfunction

  // mix of extremes, all-zero / all-one words, small values and full-range noise
  function automatic logic [31:0] rand_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return r[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
      3:       return {{20{r[11]}}, r[11:0]};
      default: return r;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following request goes out back to back.
  task automatic send_req(op_t op, logic [31:0] smp, logic [INDEX_W-1:0] idx,
                          logic [31:0] val, logic has_exp, logic [31:0] exp_out);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 15))
        0, 1, 2, 3: gap = 0;
        15:         gap = $urandom_range(64, TAPS + 64);
        default:    gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     = 1'b1;
    in_op        = op;
    in_sample_in = smp;
    in_tap_index = idx;
    in_tap_value = val;
    row_has_exp  = has_exp;
    row_exp_out  = exp_out;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding output
  task automatic hold_sender();
    in_valid = 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
  endtask

  task automatic write_shift(logic [SHIFT_W-1:0] v);
    hold_sender();
    repeat (CFG_SLACK) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    n_shift_writes++;
  endtask

  // receiver: short stall/free runs with occasional long quiet stretches
  initial begin : receiver
    int run_left;
    out_stall = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            out_stall = 1'b0;
            run_left  = $urandom_range(1000, 4000);
          end
          1, 2, 3, 4: begin
            out_stall = 1'b1;
            run_left  = $urandom_range(1, 40);
          end
          default: begin
            out_stall = 1'b0;
            run_left  = $urandom_range(1, 40);
          end
        endcase
      end else begin
        run_left--;
      end
    end
  end

  // Sample both channels at the rising edge: outputs first so a request and
  // a result on the same edge never pair up wrongly.
  always @(posedge clk) begin : monitor
    logic [31:0] want;
    logic        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_outputs++;
        if (expected_out.size() == 0) begin
          $error("sample_out: unexpected output, expected none, actual %h", out_sample_out);
          n_errors++;
        end else begin
          want = expected_out.pop_front();
          if (out_sample_out !== want) begin
            $error("sample_out mismatch: expected %h, actual %h", want, out_sample_out);
            n_errors++;
          end
        end
      end
      if (cfg_we) begin
        moved     = 1'b1;
        out_shift = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (in_op == OP_COEF) begin
          // writes past the last tap are dropped
          if (in_tap_index < TAPS) coef_bank[in_tap_index] = in_tap_value;
          n_coef_writes++;
        end else begin
          want = fir_predict(in_sample_in);
          expected_out.push_back(row_has_exp ? row_exp_out : want);
          n_samples++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $error("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int               i;
    int               item;
    logic [SHIFT_W-1:0] sh;
    stim_row_t        row;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_SAMPLE;
    in_sample_in = '0;
    in_tap_index = '0;
    in_tap_value = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    row_has_exp  = 1'b0;
    row_exp_out  = '0;
    for (i = 0; i < TAPS; i++) begin
      delay_line[i] = '0;
      coef_bank[i]  = '0;
    end
    newest_slot = 0;
    out_shift   = SHIFT_RESET;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // zero the whole bank first so no tap ever reads an unwritten coefficient
    for (i = 0; i < TAPS; i++)
      send_req(OP_COEF, $urandom, INDEX_W'(i), 32'h0, 1'b0, 32'h0);

    // directed edge cases
    for (i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_SHIFT) begin
        write_shift(row.val[SHIFT_W-1:0]);
      end else begin
        send_req(row.op, row.smp, row.idx, row.val, row.has_exp, row.exp_out);
      end
    end

    // mixed random stream of samples, coefficient updates and output shift writes
    for (item = 0; item < RAND_ITEMS; item++) begin
      if (item % 64 == 63) begin
        case ($urandom_range(0, 3))
          0:       sh = '0;
          1:       sh = '1;
          2:       sh = SHIFT_RESET;
          default: sh = SHIFT_W'($urandom_range(0, 63));
        endcase
        write_shift(sh);
      end
      // one full drain mid-stream before carrying on
      if (item == RAND_ITEMS / 2) hold_sender();
      if ($urandom_range(0, 9) < 7) begin
        send_req(OP_SAMPLE, rand_word(), INDEX_W'($urandom_range(0, 1023)), $urandom,
                 1'b0, 32'h0);
      end else begin
        send_req(OP_COEF, $urandom, INDEX_W'($urandom_range(0, 1023)), rand_word(),
                 1'b0, 32'h0);
      end
    end

    hold_sender();
    repeat (LATENCY + 8) @(negedge clk);

    $display("Ran %0d samples and %0d coefficient writes across %0d shift settings.",
             n_samples, n_coef_writes, n_shift_writes);
    $display("Compared %0d filtered outputs, %0d mismatches.", n_outputs, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
